@@ rtl/matrix_directory_key_sorter_macros.svh @@
// Assertion macros for the matrix directory key sorter.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef MATRIX_DIRECTORY_KEY_SORTER_MACROS_SVH
`define MATRIX_DIRECTORY_KEY_SORTER_MACROS_SVH

// same-cycle implication
`define MDKS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MDKS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mdks_pkg.sv @@
// Shared types, constants and key function for the matrix directory key sorter.
// No dependencies.
package mdks_pkg;

	localparam int          KEY_W           = 19;
	localparam logic [31:0] FRAME_MASK      = 32'h1FF;
	localparam logic [31:0] PLANE_LOW_MASK  = 32'hFF;
	localparam logic [31:0] PLANE_HIGH_MASK = 32'h300;
	localparam int          PLANE_LOW_SHIFT = 16;

	typedef struct packed {
		logic [31:0]        matrix_code;
		logic [31:0]        first_block;
		logic [31:0]        final_block;
		logic signed [31:0] entry_status;
		logic               is_last;
	} entry_t;

	typedef struct packed {
		logic [31:0]        out_code;
		logic [31:0]        out_first_block;
		logic [31:0]        out_final_block;
		logic signed [31:0] out_status;
		logic               out_last;
		logic               overflowed;
	} result_t;

	typedef struct packed {
		logic [31:0]        code;
		logic [31:0]        first_block;
		logic [31:0]        final_block;
		logic signed [31:0] status;
	} rec_t;

	typedef struct packed {
		logic take;
		logic start;
		logic fetch;
		logic scan;
		logic store;
		logic emit_rd;
		logic emit_ld;
	} cmd_t;

	typedef struct packed {
		logic multi;
		logic j_last;
		logic i_last;
		logic k_last;
		logic out_free;
	} sts_t;

	function automatic logic [KEY_W-1:0] sort_key(input logic [31:0] code, input logic mode);
		logic [8:0]  frame;
		logic [9:0]  plane;
		logic [31:0] hi;
		frame = 9'(code & FRAME_MASK);
		hi    = (code >> 1) & PLANE_HIGH_MASK;
		plane = 10'((code >> PLANE_LOW_SHIFT) & PLANE_LOW_MASK) + 10'(hi);
		return mode ? {frame, plane} : {plane, frame};
	endfunction

endpackage

@@ rtl/matrix_directory_key_sorter.sv @@
// Top level of the matrix directory key sorter: controller plus datapath.
// Depends on mdks_pkg, mdks_ctrl, mdks_datapath and the assertion macro header.
//
// Usage: entries arrive on entry/entry_valid, held by entry_stall. Each word is
// stored; a word with is_last set closes the list and starts an exchange sort
// on key (plane, frame), or (frame, plane) when order_mode is 1. Entries past
// MAX_ENTRIES are dropped and flag overflowed on every result of that list.
// order_mode is written through cfg_valid/cfg_data; cfg_ready is always high.
// Entries are taken back to back while idle. After the last entry, the list
// is sorted with one compare per cycle on the single read and write port of
// the entry store; each result word is then read from the store and loaded
// into the output register, which drives result/result_valid.
// result_stall holds the output register and pauses the emit; the next list can
// start loading while the final result word still waits. Reset empties the list,
// clears the overflow flag and order_mode, and drops any pending result word.
`include "matrix_directory_key_sorter_macros.svh"

module matrix_directory_key_sorter #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              entry_valid,
	output logic              entry_stall,
	input  mdks_pkg::entry_t  entry,
	output logic              result_valid,
	input  logic              result_stall,
	output mdks_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import mdks_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy;

	mdks_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.is_last     (entry.is_last),
		.sts         (sts),
		.cmd         (cmd),
		.busy        (busy)
	);

	mdks_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.entry        (entry),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign entry_stall = busy;
	assign cfg_ready   = 1'b1;

	`MDKS_ASSERT_NOW(a_pass_needs_two, cmd.fetch || cmd.scan || cmd.store, sts.multi, "sort pass on a list shorter than two")
	`MDKS_ASSERT_NOW(a_emit_into_free, cmd.emit_ld, !result_valid, "output register overwritten while holding a word")
	`MDKS_ASSERT_NEXT(a_busy_mid_list, result_valid && !result_stall && !result.out_last, entry_stall, "input taken before the list was fully emitted")

endmodule

@@ rtl/mdks_ctrl.sv @@
// Sequencer for the matrix directory key sorter: load, sort passes, emit.
// Depends on mdks_pkg for the command and status structs.
module mdks_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           entry_valid,
	input  logic           is_last,
	input  mdks_pkg::sts_t sts,
	output mdks_pkg::cmd_t cmd,
	output logic           busy
);
	import mdks_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_START   = 7'b0000010,
		S_FETCH   = 7'b0000100,
		S_SCAN    = 7'b0001000,
		S_STORE   = 7'b0010000,
		S_EMIT_RD = 7'b0100000,
		S_EMIT_LD = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.take = entry_valid;
				if (entry_valid && is_last) state_d = S_START;
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = sts.multi ? S_FETCH : S_EMIT_RD;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.j_last) state_d = S_STORE;
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = sts.i_last ? S_EMIT_RD : S_FETCH;
			end
			S_EMIT_RD: begin
				if (sts.out_free) begin
					cmd.emit_rd = 1'b1;
					state_d     = S_EMIT_LD;
				end
			end
			S_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				state_d     = sts.k_last ? S_IDLE : S_EMIT_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ rtl/mdks_datapath.sv @@
// Entry store, index counters, key compare and output register of the sorter.
// Depends on mdks_pkg for record types and the sort key function.
module mdks_datapath #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mdks_pkg::cmd_t    cmd,
	output mdks_pkg::sts_t    sts,
	input  mdks_pkg::entry_t  entry,
	input  logic              cfg_valid,
	input  logic              cfg_data,
	output logic              result_valid,
	input  logic              result_stall,
	output mdks_pkg::result_t result
);
	import mdks_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	rec_t            mem [MAX_ENTRIES];
	rec_t            rdata_s1;
	rec_t            cur_q;
	rec_t            wdata;
	result_t         out_q;
	logic            out_vld_q;
	logic [CW-1:0]   count_q;
	logic            ovf_q;
	logic            mode_q;
	logic [AW-1:0]   i_q, j_q, k_q;
	logic [AW-1:0]   raddr, waddr;
	logic            we;
	logic            room;
	logic            less;

	assign room = (count_q < CW'(MAX_ENTRIES));
	assign less = sort_key(rdata_s1.code, mode_q) < sort_key(cur_q.code, mode_q);

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = '{code: entry.matrix_code, first_block: entry.first_block,
			final_block: entry.final_block, status: entry.entry_status};
		if (cmd.take) begin
			we = room;
		end else if (cmd.scan) begin
			we    = less;
			waddr = j_q;
			wdata = cur_q;
		end else if (cmd.store) begin
			we    = 1'b1;
			waddr = i_q;
			wdata = cur_q;
		end
	end

	always_comb begin
		raddr = '0;
		if (cmd.fetch || cmd.store) raddr = i_q + AW'(1);
		else if (cmd.scan)          raddr = j_q + AW'(1);
		else if (cmd.emit_rd)       raddr = k_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch || (cmd.scan && less)) cur_q <= rdata_s1;
		if (cmd.emit_ld) begin
			out_q.out_code        <= rdata_s1.code;
			out_q.out_first_block <= rdata_s1.first_block;
			out_q.out_final_block <= rdata_s1.final_block;
			out_q.out_status      <= rdata_s1.status;
			out_q.out_last        <= sts.k_last;
			out_q.overflowed      <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			mode_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) mode_q <= cfg_data;
			if (cmd.take) begin
				if (room) count_q <= count_q + CW'(1);
				else      ovf_q   <= 1'b1;
			end
			if (cmd.start) begin
				i_q <= '0;
				k_q <= '0;
			end
			if (cmd.fetch) j_q <= i_q + AW'(1);
			if (cmd.scan)  j_q <= j_q + AW'(1);
			if (cmd.store) i_q <= i_q + AW'(1);
			if (cmd.emit_ld) begin
				k_q <= k_q + AW'(1);
				if (sts.k_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
			if (cmd.emit_ld)    out_vld_q <= 1'b1;
			else if (!result_stall) out_vld_q <= 1'b0;
		end
	end

	assign sts.multi    = (count_q >= CW'(2));
	assign sts.j_last   = (CW'(j_q) + CW'(1) == count_q);
	assign sts.i_last   = (CW'(i_q) + CW'(2) == count_q);
	assign sts.k_last   = (CW'(k_q) + CW'(1) == count_q);
	assign sts.out_free = !out_vld_q || !result_stall;

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule
